### rtl/tcsm_pkg.sv
// ----------------------------------------------------------------------------
// tcsm_pkg: shared types and constants
// States, modes, flag bits and the word formats of the TCP endpoint.
// ----------------------------------------------------------------------------
`default_nettype none
package tcsm_pkg;

  typedef enum logic [3:0] {
    ST_CLOSED     = 4'd0,
    ST_LISTEN     = 4'd1,
    ST_SYN_SENT   = 4'd2,
    ST_SYN_RCVD   = 4'd3,
    ST_ESTAB      = 4'd4,
    ST_FIN_WAIT_1 = 4'd5,
    ST_FIN_WAIT_2 = 4'd6,
    ST_CLOSE_WAIT = 4'd7,
    ST_CLOSING    = 4'd8,
    ST_LAST_ACK   = 4'd9,
    ST_TIME_WAIT  = 4'd10
  } conn_state_e;

  typedef enum logic [2:0] {
    MD_SEGMENT   = 3'd0,
    MD_TICK      = 3'd1,
    MD_CONNECT   = 3'd2,
    MD_LISTEN    = 3'd3,
    MD_ACCEPT    = 3'd4,
    MD_CLOSE     = 3'd5,
    MD_PUSH      = 3'd6,
    MD_TERMINATE = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    CR_LOCAL_PORT  = 3'd0,
    CR_REMOTE_IP   = 3'd1,
    CR_REMOTE_PORT = 3'd2,
    CR_TO_SYN_SENT = 3'd3,
    CR_TO_SYN_RCVD = 3'd4,
    CR_TO_CLOSING  = 3'd5,
    CR_TO_TIME_WAIT = 3'd6
  } cfg_reg_e;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [2:0] PF_ACK = 3'b001;
  localparam logic [2:0] PF_FIN = 3'b010;
  localparam logic [2:0] PF_PSH = 3'b100;

  localparam logic [3:0] EV_CONNECTED   = 4'b0001;
  localparam logic [3:0] EV_REQUEST     = 4'b0010;
  localparam logic [3:0] EV_PEER_CLOSED = 4'b0100;
  localparam logic [3:0] EV_TERMINATED  = 4'b1000;

  typedef struct packed {
    logic [2:0]  mode;
    logic        is_tcp_ipv4;
    logic        checksum_ok;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [3:0]  seg_flags;
    logic [15:0] payload_len;
    logic [15:0] tx_pending;
  } in_word_t;

  typedef struct packed {
    logic        consumed;
    logic        send_segment;
    logic        with_mss_option;
    logic [3:0]  out_flags;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic        with_data;
    logic [11:0] deliver_len;
    logic [15:0] release_bytes;
    logic [3:0]  conn_state;
    logic [3:0]  events;
  } out_word_t;

  // classified word handed from front to back
  typedef struct packed {
    mode_e       mode;
    logic        matched;
    logic        cks_ok;
    logic        syn;
    logic        ack;
    logic        fin;
    logic        rst;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [15:0] payload_len;
    logic [15:0] tx_pending;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/tcsm_if.sv
// ----------------------------------------------------------------------------
// tcsm_if: valid/ready channels
// Item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none
interface tcsm_in_if;
  logic                valid;
  logic                ready;
  tcsm_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tcsm_out_if;
  logic                valid;
  logic                ready;
  tcsm_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tcsm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tcsm_pkg::CfgIdxW-1:0]  index;
  logic [tcsm_pkg::CfgDataW-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

### rtl/tcsm_front.sv
// ----------------------------------------------------------------------------
// tcsm_front: item intake and classification
// Decodes flags and matches the port; the peer match needs back state and
// is finished in the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module tcsm_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  tcsm_in_if.sink                  in_if,
  input  wire logic [15:0]         local_port_i,
  output tcsm_pkg::cmd_t           cmd_o,
  output logic                     cmd_valid_o,
  input  wire logic                cmd_ready_i
);

  tcsm_pkg::cmd_t cmd_q, cmd_d;
  logic           valid_q;

  assign in_if.ready = !valid_q || cmd_ready_i;

  always_comb begin
    cmd_d             = '0;
    cmd_d.mode        = tcsm_pkg::mode_e'(in_if.data.mode);
    // port and ip/tcp part of the match; peer part done downstream
    cmd_d.matched     = in_if.data.is_tcp_ipv4 && (in_if.data.dst_port == local_port_i);
    cmd_d.cks_ok      = in_if.data.checksum_ok;
    cmd_d.syn         = in_if.data.seg_flags[0];
    cmd_d.ack         = in_if.data.seg_flags[1];
    cmd_d.fin         = in_if.data.seg_flags[2];
    cmd_d.rst         = in_if.data.seg_flags[3];
    cmd_d.src_ip      = in_if.data.src_ip;
    cmd_d.src_port    = in_if.data.src_port;
    cmd_d.seg_seq     = in_if.data.seg_seq;
    cmd_d.seg_ack     = in_if.data.seg_ack;
    cmd_d.payload_len = in_if.data.payload_len;
    cmd_d.tx_pending  = in_if.data.tx_pending;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_if.ready) begin
      valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_o       = cmd_q;
  assign cmd_valid_o = valid_q;

endmodule
`default_nettype wire

### rtl/tcsm_queue.sv
// ----------------------------------------------------------------------------
// tcsm_queue: two-entry word queue
// Decouples the classifier from the state engine.
// ----------------------------------------------------------------------------
`default_nettype none
module tcsm_queue (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  tcsm_pkg::cmd_t wr_data_i,
  input  wire logic      wr_valid_i,
  output logic           wr_ready_o,
  output tcsm_pkg::cmd_t rd_data_o,
  output logic           rd_valid_o,
  input  wire logic      rd_ready_i
);

  tcsm_pkg::cmd_t mem_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           wr_en, rd_en;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) wp_q <= !wp_q;
      if (rd_en) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

endmodule
`default_nettype wire

### rtl/tcsm_back.sv
// ----------------------------------------------------------------------------
// tcsm_back: connection state engine
// Applies one classified word per cycle, unless the output stalls, to the
// connection state and registers the result word.
// ----------------------------------------------------------------------------
`default_nettype none
module tcsm_back #(
  parameter int RxPayloadMax = 1460
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  tcsm_pkg::cmd_t cmd_i,
  input  wire logic      cmd_valid_i,
  output logic           cmd_ready_o,
  tcsm_out_if.source     out_if,
  input  wire logic [31:0] remote_ip_i,
  input  wire logic [15:0] remote_port_i,
  input  wire logic [7:0]  to_syn_sent_i,
  input  wire logic [7:0]  to_syn_rcvd_i,
  input  wire logic [7:0]  to_closing_i,
  input  wire logic [7:0]  to_time_wait_i
);

  localparam logic [11:0] RxMax = 12'(RxPayloadMax);

  tcsm_pkg::conn_state_e st_q, st_d;
  logic [31:0] sseq_q, sseq_d, rack_q, rack_d;
  logic [7:0]  tmr_q, tmr_d;
  logic [2:0]  pf_q, pf_d;
  logic [31:0] pip_q, pip_d, lip_q, lip_d, lseq_q, lseq_d;
  logic [15:0] pport_q, pport_d, lport_q, lport_d;
  tcsm_pkg::out_word_t res, out_q;
  logic        ovalid_q, take;

  logic [31:0] diff;
  logic [32:0] backed, bk2;
  logic        pos, syn_st;
  logic [15:0] txp;

  assign cmd_ready_o = !ovalid_q || out_if.ready;
  assign take        = cmd_valid_i && cmd_ready_o;

  always_comb begin
    st_d = st_q; sseq_d = sseq_q; rack_d = rack_q; tmr_d = tmr_q; pf_d = pf_q;
    pip_d = pip_q; pport_d = pport_q; lip_d = lip_q; lport_d = lport_q;
    lseq_d = lseq_q;
    res = '0;
    txp = cmd_i.tx_pending;
    diff = cmd_i.seg_ack - sseq_q;
    backed = {diff[31], diff};
    bk2 = backed;
    pos = 1'b0;
    syn_st = 1'b0;
    case (cmd_i.mode)
      tcsm_pkg::MD_SEGMENT: begin
        if (cmd_i.matched && st_q != tcsm_pkg::ST_CLOSED &&
            ((pip_q == cmd_i.src_ip && pport_q == cmd_i.src_port) ||
             st_q == tcsm_pkg::ST_LISTEN)) begin
          res.consumed = 1'b1;
          lip_d = cmd_i.src_ip; lport_d = cmd_i.src_port; lseq_d = cmd_i.seg_seq;
          if (cmd_i.cks_ok) begin
            if (cmd_i.rst) begin
              if (st_q != tcsm_pkg::ST_LISTEN) begin
                st_d = tcsm_pkg::ST_CLOSED; tmr_d = '0;
                res.release_bytes = txp; res.events = tcsm_pkg::EV_TERMINATED;
              end
            end else begin
              if (!backed[32] && backed != '0) sseq_d = cmd_i.seg_ack;
              if (st_q == tcsm_pkg::ST_SYN_SENT && cmd_i.syn && cmd_i.ack) begin
                rack_d = cmd_i.seg_seq + 32'd1;
                st_d = tcsm_pkg::ST_ESTAB; tmr_d = '0;
                pf_d = pf_q | tcsm_pkg::PF_ACK;
                res.events = tcsm_pkg::EV_CONNECTED;
              end else if (st_q == tcsm_pkg::ST_LISTEN && cmd_i.syn) begin
                res.events = tcsm_pkg::EV_REQUEST;
              end else if (!(st_q == tcsm_pkg::ST_SYN_RCVD && !cmd_i.ack)) begin
                if (st_q == tcsm_pkg::ST_SYN_RCVD) begin
                  syn_st = 1'b1;
                  st_d = tcsm_pkg::ST_ESTAB; tmr_d = '0;
                  res.events = tcsm_pkg::EV_CONNECTED;
                  bk2 = backed - 33'd1;
                end
                pos = !bk2[32] && bk2 != '0;
                if (pos) begin
                  if (bk2 < {17'd0, txp}) begin
                    res.release_bytes = bk2[15:0];
                    bk2 = '0;
                  end else begin
                    res.release_bytes = txp;
                    bk2 = bk2 - {17'd0, txp};
                  end
                end
                if (rack_q != cmd_i.seg_seq) begin
                  pf_d = pf_d | tcsm_pkg::PF_ACK;
                end else begin
                  rack_d = rack_q + {16'd0, cmd_i.payload_len} + {31'd0, cmd_i.fin};
                  if (cmd_i.payload_len != '0) begin
                    pf_d = pf_d | tcsm_pkg::PF_ACK;
                    res.deliver_len = (cmd_i.payload_len < {4'd0, RxMax}) ?
                                      cmd_i.payload_len[11:0] : RxMax;
                  end
                  // a SYN_RCVD word promoted above is handled as ESTAB
                  case (syn_st ? tcsm_pkg::ST_ESTAB : st_q)
                    tcsm_pkg::ST_ESTAB: begin
                      if (cmd_i.fin) begin
                        st_d = tcsm_pkg::ST_CLOSE_WAIT; tmr_d = '0;
                        res.events = res.events | tcsm_pkg::EV_PEER_CLOSED;
                      end
                    end
                    tcsm_pkg::ST_FIN_WAIT_1: begin
                      if (bk2 == 33'd1 && res.release_bytes == txp) begin
                        if (cmd_i.fin) begin
                          st_d = tcsm_pkg::ST_TIME_WAIT; tmr_d = to_time_wait_i;
                          res.events = res.events | tcsm_pkg::EV_PEER_CLOSED;
                        end else begin
                          st_d = tcsm_pkg::ST_FIN_WAIT_2; tmr_d = to_closing_i;
                        end
                      end else if (cmd_i.fin) begin
                        st_d = tcsm_pkg::ST_CLOSING; tmr_d = to_closing_i;
                        pf_d = pf_d | tcsm_pkg::PF_ACK;
                        res.events = res.events | tcsm_pkg::EV_PEER_CLOSED;
                      end
                    end
                    tcsm_pkg::ST_CLOSING: begin
                      if (bk2 == 33'd1 && res.release_bytes == txp) begin
                        st_d = tcsm_pkg::ST_TIME_WAIT; tmr_d = to_time_wait_i;
                      end else begin
                        pf_d = pf_d | tcsm_pkg::PF_ACK;
                      end
                    end
                    tcsm_pkg::ST_FIN_WAIT_2: begin
                      if (cmd_i.fin) begin
                        st_d = tcsm_pkg::ST_TIME_WAIT; tmr_d = to_time_wait_i;
                        pf_d = pf_d | tcsm_pkg::PF_ACK;
                        res.events = res.events | tcsm_pkg::EV_PEER_CLOSED;
                      end
                    end
                    tcsm_pkg::ST_LAST_ACK: begin
                      st_d = tcsm_pkg::ST_CLOSED; tmr_d = '0;
                      res.release_bytes = txp;
                      res.events = res.events | tcsm_pkg::EV_TERMINATED;
                    end
                    default: ;
                  endcase
                end
              end
            end
          end
        end
      end
      tcsm_pkg::MD_TICK: begin
        if (tmr_q == 8'd1 && st_q != tcsm_pkg::ST_CLOSED && st_q != tcsm_pkg::ST_LISTEN &&
            st_q != tcsm_pkg::ST_ESTAB && st_q != tcsm_pkg::ST_CLOSE_WAIT) begin
          st_d = tcsm_pkg::ST_CLOSED; tmr_d = '0;
          res.release_bytes = txp; res.events = tcsm_pkg::EV_TERMINATED;
        end else begin
          if (tmr_q != '0) tmr_d = tmr_q - 8'd1;
          case (st_q)
            tcsm_pkg::ST_SYN_SENT, tcsm_pkg::ST_SYN_RCVD: begin
              res.send_segment = 1'b1; res.with_mss_option = 1'b1;
              res.out_flags = (st_q == tcsm_pkg::ST_SYN_RCVD) ? 4'd3 : 4'd1;
              res.out_seq = sseq_q; res.out_ack = rack_q;
            end
            tcsm_pkg::ST_CLOSING, tcsm_pkg::ST_FIN_WAIT_1, tcsm_pkg::ST_LAST_ACK,
            tcsm_pkg::ST_FIN_WAIT_2, tcsm_pkg::ST_TIME_WAIT, tcsm_pkg::ST_ESTAB: begin
              if (st_q == tcsm_pkg::ST_FIN_WAIT_2) pf_d = pf_d | tcsm_pkg::PF_ACK;
              if ((st_q == tcsm_pkg::ST_CLOSING || st_q == tcsm_pkg::ST_FIN_WAIT_1 ||
                   st_q == tcsm_pkg::ST_LAST_ACK) &&
                  (st_q == tcsm_pkg::ST_LAST_ACK || txp == '0))
                pf_d = pf_d | tcsm_pkg::PF_FIN | tcsm_pkg::PF_ACK;
              if (txp != '0) pf_d = pf_d | tcsm_pkg::PF_ACK;
              if (pf_d != '0) begin
                res.send_segment = 1'b1; res.out_flags = {pf_d, 1'b0};
                res.out_seq = sseq_q; res.out_ack = rack_q;
                res.with_data = txp != '0; pf_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      tcsm_pkg::MD_CONNECT: begin
        rack_d = '0; pip_d = remote_ip_i; pport_d = remote_port_i;
        st_d = tcsm_pkg::ST_SYN_SENT; tmr_d = to_syn_sent_i;
        res.send_segment = 1'b1; res.with_mss_option = 1'b1; res.out_flags = 4'd1;
        res.out_seq = sseq_q; res.out_ack = rack_d;
      end
      tcsm_pkg::MD_LISTEN: begin
        pip_d = '0; st_d = tcsm_pkg::ST_LISTEN; tmr_d = '0;
      end
      tcsm_pkg::MD_ACCEPT: begin
        pip_d = lip_q; pport_d = lport_q; rack_d = lseq_q + 32'd1;
        res.send_segment = 1'b1; res.with_mss_option = 1'b1; res.out_flags = 4'd3;
        res.out_seq = sseq_q; res.out_ack = rack_d;
        st_d = tcsm_pkg::ST_SYN_RCVD; tmr_d = to_syn_rcvd_i;
      end
      tcsm_pkg::MD_CLOSE: begin
        if (st_q == tcsm_pkg::ST_CLOSE_WAIT) begin
          st_d = tcsm_pkg::ST_LAST_ACK; tmr_d = to_closing_i;
        end else if (st_q == tcsm_pkg::ST_ESTAB) begin
          st_d = tcsm_pkg::ST_FIN_WAIT_1; tmr_d = to_closing_i;
        end
      end
      tcsm_pkg::MD_PUSH: begin
        pf_d = pf_q | tcsm_pkg::PF_PSH;
        if (txp != '0) pf_d = pf_d | tcsm_pkg::PF_ACK;
        res.send_segment = 1'b1; res.out_flags = {pf_d, 1'b0};
        res.out_seq = sseq_q; res.out_ack = rack_q;
        res.with_data = txp != '0; pf_d = '0;
      end
      default: begin
        st_d = tcsm_pkg::ST_CLOSED; tmr_d = '0;
        res.release_bytes = txp; res.events = tcsm_pkg::EV_TERMINATED;
      end
    endcase
    res.conn_state = st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= tcsm_pkg::ST_CLOSED; sseq_q <= '0; rack_q <= '0; tmr_q <= '0;
      pf_q <= '0; pip_q <= '0; pport_q <= '0; lip_q <= '0; lport_q <= '0;
      lseq_q <= '0; ovalid_q <= 1'b0;
    end else begin
      if (take) begin
        st_q <= st_d; sseq_q <= sseq_d; rack_q <= rack_d; tmr_q <= tmr_d;
        pf_q <= pf_d; pip_q <= pip_d; pport_q <= pport_d; lip_q <= lip_d;
        lport_q <= lport_d; lseq_q <= lseq_d;
      end
      if (cmd_ready_o) ovalid_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) out_q <= res;
  end

  assign out_if.valid = ovalid_q;
  assign out_if.data  = out_q;

endmodule
`default_nettype wire

### rtl/tcp_connection_state_machine.sv
// ----------------------------------------------------------------------------
// tcp_connection_state_machine: single TCP connection endpoint
// Classifier front end, two-word queue and connection state engine.
// ----------------------------------------------------------------------------
//  channel   dir   word         handshake
//  in_if     in    in_word_t    valid/ready
//  out_if    out   out_word_t   valid/ready
//  cfg_if    in    index/wdata  valid/ready, always ready
//
// One word per cycle sustained unless the output stalls; words pass through
// the front register, the queue and the result register. The state engine
// updates as it takes each word, so words follow back to back. Reset clears
// connection state, valid flags and configuration; timeouts reset to 10. A
// stalled output holds the engine; the queue absorbs the front end's word.
`default_nettype none
module tcp_connection_state_machine #(
  parameter int RX_PAYLOAD_MAX = 1460
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tcsm_in_if.sink   in_if,
  tcsm_out_if.source out_if,
  tcsm_cfg_if.sink  cfg_if
);

  logic [15:0] local_port_q, remote_port_q;
  logic [31:0] remote_ip_q;
  logic [7:0]  to_ss_q, to_sr_q, to_cl_q, to_tw_q;

  tcsm_pkg::cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_port_q <= '0; remote_ip_q <= '0; remote_port_q <= '0;
      to_ss_q <= 8'd10; to_sr_q <= 8'd10; to_cl_q <= 8'd10; to_tw_q <= 8'd10;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        tcsm_pkg::CR_LOCAL_PORT:   local_port_q  <= cfg_if.wdata[15:0];
        tcsm_pkg::CR_REMOTE_IP:    remote_ip_q   <= cfg_if.wdata;
        tcsm_pkg::CR_REMOTE_PORT:  remote_port_q <= cfg_if.wdata[15:0];
        tcsm_pkg::CR_TO_SYN_SENT:  to_ss_q       <= cfg_if.wdata[7:0];
        tcsm_pkg::CR_TO_SYN_RCVD:  to_sr_q       <= cfg_if.wdata[7:0];
        tcsm_pkg::CR_TO_CLOSING:   to_cl_q       <= cfg_if.wdata[7:0];
        tcsm_pkg::CR_TO_TIME_WAIT: to_tw_q       <= cfg_if.wdata[7:0];
        default: ;
      endcase
    end
  end

  tcsm_front u_front (
    .clk_i, .rst_ni, .in_if, .local_port_i(local_port_q),
    .cmd_o(f_cmd), .cmd_valid_o(f_valid), .cmd_ready_i(f_ready)
  );

  tcsm_queue u_queue (
    .clk_i, .rst_ni, .wr_data_i(f_cmd), .wr_valid_i(f_valid), .wr_ready_o(f_ready),
    .rd_data_o(q_cmd), .rd_valid_o(q_valid), .rd_ready_i(q_ready)
  );

  tcsm_back #(.RxPayloadMax(RX_PAYLOAD_MAX)) u_back (
    .clk_i, .rst_ni, .cmd_i(q_cmd), .cmd_valid_i(q_valid), .cmd_ready_o(q_ready),
    .out_if, .remote_ip_i(remote_ip_q), .remote_port_i(remote_port_q),
    .to_syn_sent_i(to_ss_q), .to_syn_rcvd_i(to_sr_q),
    .to_closing_i(to_cl_q), .to_time_wait_i(to_tw_q)
  );

endmodule
`default_nettype wire

### rtl/tcsm_checker.sv
// ----------------------------------------------------------------------------
// tcsm_checker: port-level checks
// Result word sanity seen at the top level's ports.
// ----------------------------------------------------------------------------
`default_nettype none
module tcsm_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid,
  input wire logic out_ready,
  input tcsm_pkg::out_word_t out_data
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.send_segment |-> out_data.out_flags == '0 &&
    out_data.out_seq == '0 && !out_data.with_data)
    else $error("segment fields set without a send");

  a_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.events[3] |-> out_data.conn_state == 4'd0)
    else $error("terminated but not closed");

  a_mss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.with_mss_option |-> out_data.out_flags[0])
    else $error("MSS option without SYN");

endmodule

bind tcp_connection_state_machine tcsm_checker u_tcsm_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid(out_if.valid),
  .out_ready(out_if.ready), .out_data(out_if.data)
);
`default_nettype wire
